FILE: rtl/hhlp_pkg.sv
`timescale 1ns / 1ps

package hhlp_pkg;

  // Largest header block, in bytes, before the position overflows.
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 65536;

  // Field widths.
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned PH_W   = 3;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Parse phases.
  localparam logic [PH_W-1:0] PH_LINE      = 3'd0;
  localparam logic [PH_W-1:0] PH_KEY       = 3'd1;
  localparam logic [PH_W-1:0] PH_KEY_BLANK = 3'd2;
  localparam logic [PH_W-1:0] PH_VAL_BLANK = 3'd3;
  localparam logic [PH_W-1:0] PH_VALUE     = 3'd4;
  localparam logic [PH_W-1:0] PH_VALUE_CR  = 3'd5;
  localparam logic [PH_W-1:0] PH_EMPTY_CR  = 3'd6;
  localparam logic [PH_W-1:0] PH_HOLD      = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_PAIR      = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } hhlp_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OFS_W-1:0] key_offset;
    logic [OFS_W-1:0] key_length;
    logic [OFS_W-1:0] value_offset;
    logic [OFS_W-1:0] value_length;
    logic [POS_W-1:0] header_bytes;
  } hhlp_out_t;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [POS_W-1:0] position;
    logic [OFS_W-1:0] key_start;
    logic [OFS_W-1:0] key_count;
    logic [OFS_W-1:0] value_start;
    logic [OFS_W-1:0] last_nonblank;
  } hhlp_state_t;

  // Space or horizontal tab.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

FILE: rtl/hhlp_step.sv
`timescale 1ns / 1ps

module hhlp_step
  import hhlp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  hhlp_state_t      cur,
  input  logic [OFS_W-1:0] start_position,
  input  hhlp_in_t         item,
  output hhlp_state_t      nxt,
  output logic             res_valid,
  output hhlp_out_t        res
);

  hhlp_state_t      st;
  logic [POS_W:0]   abs_pos;
  logic [OFS_W-1:0] p;
  logic [7:0]       c;
  logic             overflow;

  assign c = item.byte_in;

  // One byte of the parse: next state and at most one result.
  always_comb begin
    st = cur;
    if (item.restart) begin
      st.phase    = PH_LINE;
      st.position = '0;
    end
    nxt       = st;
    res_valid = 1'b0;
    res       = '0;

    abs_pos  = {1'b0, st.position} + {{(POS_W + 1 - OFS_W){1'b0}}, start_position};
    overflow = (32'(st.position) >= 32'(MAX_BLOCK_BYTES)) ||
               (abs_pos > {{(POS_W + 1 - OFS_W){1'b0}}, {OFS_W{1'b1}}});
    p        = abs_pos[OFS_W-1:0];

    if (st.phase != PH_HOLD) begin
      if (overflow) begin
        res_valid = 1'b1;
        res.kind  = KIND_OVERFLOW;
        nxt.phase = PH_HOLD;
      end else begin
        nxt.position = st.position + 1'b1;
        case (st.phase)
          PH_LINE: begin
            if (is_blank(c)) begin
              nxt.phase = PH_LINE;
            end else if (c == CH_COLON || c == CH_LF) begin
              res_valid = 1'b1;
              res.kind  = KIND_MALFORMED;
            end else if (c == CH_CR) begin
              nxt.phase = PH_EMPTY_CR;
            end else begin
              nxt.key_start = p;
              nxt.phase     = PH_KEY;
            end
          end
          PH_KEY: begin
            if (c == CH_CR || c == CH_LF) begin
              res_valid = 1'b1;
              res.kind  = KIND_MALFORMED;
            end else if (is_blank(c)) begin
              nxt.key_count = p - st.key_start;
              nxt.phase     = PH_KEY_BLANK;
            end else if (c == CH_COLON) begin
              nxt.key_count = p - st.key_start;
              nxt.phase     = PH_VAL_BLANK;
            end
          end
          PH_KEY_BLANK: begin
            if (c == CH_COLON) begin
              nxt.phase = PH_VAL_BLANK;
            end else if (!is_blank(c)) begin
              res_valid = 1'b1;
              res.kind  = KIND_MALFORMED;
            end
          end
          PH_VAL_BLANK: begin
            if (c == CH_CR || c == CH_LF) begin
              res_valid = 1'b1;
              res.kind  = KIND_MALFORMED;
            end else if (!is_blank(c)) begin
              nxt.value_start   = p;
              nxt.last_nonblank = p;
              nxt.phase         = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (c == CH_LF) begin
              res_valid = 1'b1;
              res.kind  = KIND_MALFORMED;
            end else if (c == CH_CR) begin
              nxt.phase = PH_VALUE_CR;
            end else if (!is_blank(c)) begin
              nxt.last_nonblank = p;
            end
          end
          PH_VALUE_CR: begin
            res_valid = 1'b1;
            if (c == CH_LF) begin
              res.kind         = KIND_PAIR;
              res.key_offset   = st.key_start;
              res.key_length   = st.key_count;
              res.value_offset = st.value_start;
              res.value_length = st.last_nonblank + 1'b1 - st.value_start;
            end else begin
              res.kind = KIND_MALFORMED;
            end
          end
          PH_EMPTY_CR: begin
            res_valid = 1'b1;
            if (c == CH_LF) begin
              res.kind         = KIND_END;
              res.header_bytes = nxt.position;
            end else begin
              res.kind = KIND_MALFORMED;
            end
          end
          default: begin
            nxt.phase = PH_HOLD;
          end
        endcase
        // A pair returns to line start; every other result holds.
        if (res_valid) begin
          nxt.phase = (res.kind == KIND_PAIR) ? PH_LINE : PH_HOLD;
        end
      end
    end
  end

endmodule

FILE: rtl/http_header_line_parser_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload     Handshake
// in_      input      hhlp_in_t   in_valid / in_stall
// out_     output     hhlp_out_t  out_valid / out_stall
// cfg_     input      16 bits     cfg_wr_en, no wait
//
// A byte is taken into the input register, parsed from there, and its result,
// if any, is registered in the output register. One byte per cycle is
// sustained while the output does not stall. The parse state is updated only
// when a byte moves from the input register into the parse step. A stall on
// the output holds the result register and then the input register.
// Reset is synchronous and returns the parser to line start at position zero.

module http_header_line_parser_unit
  import hhlp_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  hhlp_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output hhlp_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [OFS_W-1:0] cfg_wr_data
);

  logic             in_valid_r;
  hhlp_in_t         in_data_r;
  logic             out_valid_r;
  hhlp_out_t        out_data_r;
  hhlp_state_t      state_r;
  hhlp_state_t      state_nxt;
  logic [OFS_W-1:0] start_position_r;
  logic             res_valid;
  hhlp_out_t        res;
  logic             advance;
  logic             in_take;

  // The held byte moves on unless a result waits and is stalled.
  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hhlp_step #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_step (
    .cur           (state_r),
    .start_position(start_position_r),
    .item          (in_data_r),
    .nxt           (state_nxt),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_position_r <= '0;
    end else if (cfg_wr_en) begin
      start_position_r <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  // Parse state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_LINE;
      state_r.position      <= '0;
      state_r.key_start     <= '0;
      state_r.key_count     <= '0;
      state_r.value_start   <= '0;
      state_r.last_nonblank <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
